>>> rtl/sobg_pkg.sv
// Shared types and constants for the 3x3 Sobel gradient block.
// Holds the queue entry layout passed from the front end to the back end.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sobg_pkg;

  // Queue between the front and back ends
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QLVL_W      = 3;

  // Magnitude ceiling
  localparam logic [7:0] SAT_MAX = 8'd255;

  // Input item codes
  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_DRAIN = 1'b1;

  // Register indexes on the configuration port
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // One column of the 3x3 neighbourhood, rows already clamped
  typedef struct packed {
    logic [7:0] t;
    logic [7:0] m;
    logic [7:0] b;
  } col_t;

  // One result to compute: left, centre and right columns plus tags
  typedef struct packed {
    col_t       l;
    col_t       c;
    col_t       r;
    logic [9:0] x;
    logic [9:0] y;
    logic       run_end;
    logic       frame_end;
  } job_t;

  // A queue entry carries one or two jobs; a single job sits in j1
  typedef struct packed {
    logic two;
    job_t j0;
    job_t j1;
  } entry_t;

  // Row bank of the three-row line store, counting modulo 3
  function automatic logic [1:0] bank_inc(input logic [1:0] b);
    case (b)
      2'd0:    return 2'd1;
      2'd1:    return 2'd2;
      default: return 2'd0;
    endcase
  endfunction

  function automatic logic [1:0] bank_dec(input logic [1:0] b);
    case (b)
      2'd1:    return 2'd0;
      2'd2:    return 2'd1;
      default: return 2'd2;
    endcase
  endfunction

endpackage

`default_nettype wire

>>> rtl/sobg_queue.sv
// Short entry queue between the front end and the back end.
// Depends on sobg_pkg for the entry type and depth.
`timescale 1ns / 1ps
`default_nettype none

module sobg_queue
  import sobg_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  entry_t            push_entry,
  input  logic              pop,
  output entry_t            head,
  output logic              head_valid,
  output logic [QLVL_W-1:0] level
);

  entry_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_entry;
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      level <= level + QLVL_W'(push) - QLVL_W'(pop);
    end
  end

  assign head       = slots[rd_ptr];
  assign head_valid = (level != '0);

`ifndef SYNTHESIS
  // Front-end credit check must keep the queue from overflowing
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (level < QLVL_W'(QUEUE_DEPTH)))
    else $error("queue overflow");

  // The back end only pops a present entry
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> (level != '0))
    else $error("queue underflow");
`endif

endmodule

`default_nettype wire

>>> rtl/sobg_front.sv
// Front end: accepts items, tracks raster position, owns the line store
// and the column window, and builds queue entries. Depends on sobg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sobg_front
  import sobg_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
)
(
  input  logic              clk,
  input  logic              rst,
  input  logic              restart,
  input  logic [10:0]       frame_width,
  input  logic [10:0]       frame_height,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              func,
  input  logic [7:0]        pixel,
  input  logic [QLVL_W-1:0] q_level,
  output logic              push,
  output entry_t            push_entry
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  // Registered transaction info handed from the accept stage to the build stage
  typedef struct packed {
    logic       push;
    logic       drain;
    logic [7:0] pix;
    logic       e_first;
    logic       wrap;
    logic       e_last;
    logic       c_one;
    logic       w_one;
    logic       h_one;
    logic       top_clamp;
    logic [1:0] bm1;
    logic [1:0] bm2;
    logic [1:0] lb;
    logic [1:0] pb;
    logic       x_zero;
    logic       d_last;
    logic [9:0] x_first;
    logic [9:0] y_first;
    logic [9:0] x_last;
    logic [9:0] y_last;
  } s1_t;

  logic [CW-1:0] wm1;
  logic [RW-1:0] hm1;

  logic [CW-1:0] in_col;
  logic [RW-1:0] in_row;
  logic [1:0]    bank;
  logic          draining;
  logic [CW-1:0] drain_col;
  logic [1:0]    last_bank;
  logic [1:0]    prev_bank;

  logic          fire, is_pix, is_drn;
  logic          col_end, frame_last;
  logic          e_norm, e_wrap, e_last;
  logic [CW-1:0] rd_addr_a, rd_addr_b;

  s1_t           s1, s1_next;
  logic          s1_valid;
  logic [7:0]    rd_a [3];
  logic [7:0]    rd_b [3];

  col_t          win_p1, win_p2;
  col_t          cur_col, col_a, col_b;
  job_t          job_first, job_last, job_drain;

  function automatic logic [7:0] pick3(input logic [1:0] sel, input logic [7:0] v0,
                                       input logic [7:0] v1, input logic [7:0] v2);
    case (sel)
      2'd0:    return v0;
      2'd1:    return v1;
      default: return v2;
    endcase
  endfunction

  // Effective frame size, last column and last row
  always_comb begin
    if (frame_width == '0)                wm1 = '0;
    else if (32'(frame_width) > MAX_WIDTH) wm1 = CW'(MAX_WIDTH - 1);
    else                                   wm1 = CW'(frame_width - 11'd1);
    if (frame_height == '0)                 hm1 = '0;
    else if (32'(frame_height) > MAX_HEIGHT) hm1 = RW'(MAX_HEIGHT - 1);
    else                                     hm1 = RW'(frame_height - 11'd1);
  end

  // Accept and classify
  assign in_stall = (q_level + QLVL_W'(s1_valid & s1.push)) >= QLVL_W'(QUEUE_DEPTH);
  assign fire     = in_valid && !in_stall;
  assign is_pix   = fire && (func == FUNC_PIXEL) && !draining;
  assign is_drn   = fire && (func == FUNC_DRAIN) && draining;

  assign col_end    = (in_col == wm1);
  assign frame_last = col_end && (in_row == hm1);
  assign e_norm     = (in_row != '0) && (in_col != '0);
  assign e_wrap     = (in_col == '0) && (in_row > RW'(1));
  assign e_last     = frame_last && (hm1 != '0);

  assign rd_addr_a = draining ? drain_col : in_col;
  assign rd_addr_b = (drain_col == wm1) ? drain_col : drain_col + CW'(1);

  always_comb begin
    s1_next           = s1;
    s1_next.push      = is_pix ? (e_norm | e_wrap | e_last) : 1'b1;
    s1_next.drain     = is_drn;
    s1_next.pix       = pixel;
    s1_next.e_first   = e_norm | e_wrap;
    s1_next.wrap      = e_wrap;
    s1_next.e_last    = e_last;
    s1_next.c_one     = (in_col == CW'(1));
    s1_next.w_one     = (wm1 == '0);
    s1_next.h_one     = (hm1 == '0);
    s1_next.top_clamp = (in_row == RW'(1));
    s1_next.bm1       = bank_dec(bank);
    s1_next.bm2       = bank_dec(bank_dec(bank));
    s1_next.lb        = last_bank;
    s1_next.pb        = prev_bank;
    s1_next.x_zero    = (drain_col == '0);
    s1_next.d_last    = (drain_col == wm1);
    s1_next.x_last    = 10'(wm1);
    s1_next.y_last    = 10'(hm1 - RW'(1));
    if (draining) begin
      s1_next.x_first = 10'(drain_col);
      s1_next.y_first = 10'(hm1);
    end else if (e_wrap) begin
      s1_next.x_first = 10'(wm1);
      s1_next.y_first = 10'(in_row - RW'(2));
    end else begin
      s1_next.x_first = 10'(in_col - CW'(1));
      s1_next.y_first = 10'(in_row - RW'(1));
    end
  end

  // Raster position and drain tracking
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      in_col    <= '0;
      in_row    <= '0;
      bank      <= '0;
      draining  <= 1'b0;
      drain_col <= '0;
    end else if (is_pix) begin
      if (frame_last) begin
        in_col    <= '0;
        in_row    <= '0;
        bank      <= '0;
        draining  <= 1'b1;
        drain_col <= '0;
        last_bank <= bank;
        prev_bank <= bank_dec(bank);
      end else if (col_end) begin
        in_col <= '0;
        in_row <= in_row + RW'(1);
        bank   <= bank_inc(bank);
      end else begin
        in_col <= in_col + CW'(1);
      end
    end else if (is_drn) begin
      if (drain_col == wm1) begin
        draining  <= 1'b0;
        drain_col <= '0;
      end else begin
        drain_col <= drain_col + CW'(1);
      end
    end
  end

  // Line store, one bank per row modulo 3, two registered read ports each
  for (genvar g = 0; g < 3; g++) begin : g_bank
    logic [7:0] line_mem [MAX_WIDTH];
    always_ff @(posedge clk) begin
      if (is_pix && (bank == 2'(g))) line_mem[in_col] <= pixel;
      rd_a[g] <= line_mem[rd_addr_a];
      rd_b[g] <= line_mem[rd_addr_b];
    end
  end

  // Build stage register
  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else     s1_valid <= is_pix | is_drn;
  end

  always_ff @(posedge clk) begin
    s1 <= s1_next;
  end

  // Columns formed from the store reads
  always_comb begin
    cur_col.m = pick3(s1.bm1, rd_a[0], rd_a[1], rd_a[2]);
    cur_col.t = s1.top_clamp ? cur_col.m : pick3(s1.bm2, rd_a[0], rd_a[1], rd_a[2]);
    cur_col.b = s1.pix;

    col_a.m = pick3(s1.lb, rd_a[0], rd_a[1], rd_a[2]);
    col_a.b = col_a.m;
    col_a.t = s1.h_one ? col_a.m : pick3(s1.pb, rd_a[0], rd_a[1], rd_a[2]);

    col_b.m = pick3(s1.lb, rd_b[0], rd_b[1], rd_b[2]);
    col_b.b = col_b.m;
    col_b.t = s1.h_one ? col_b.m : pick3(s1.pb, rd_b[0], rd_b[1], rd_b[2]);
  end

  // Jobs: in-row or end-of-row result, frame's closing result, drain result
  always_comb begin
    job_first.l         = (s1.wrap ? s1.w_one : s1.c_one) ? win_p1 : win_p2;
    job_first.c         = win_p1;
    job_first.r         = s1.wrap ? win_p1 : cur_col;
    job_first.x         = s1.x_first;
    job_first.y         = s1.y_first;
    job_first.run_end   = !s1.e_last;
    job_first.frame_end = 1'b0;

    job_last.l          = s1.w_one ? cur_col : win_p1;
    job_last.c          = cur_col;
    job_last.r          = cur_col;
    job_last.x          = s1.x_last;
    job_last.y          = s1.y_last;
    job_last.run_end    = 1'b1;
    job_last.frame_end  = 1'b0;

    job_drain.l         = s1.x_zero ? col_a : win_p1;
    job_drain.c         = col_a;
    job_drain.r         = col_b;
    job_drain.x         = s1.x_first;
    job_drain.y         = s1.y_first;
    job_drain.run_end   = 1'b1;
    job_drain.frame_end = s1.d_last;
  end

  always_comb begin
    push_entry.two = 1'b0;
    push_entry.j0  = job_first;
    push_entry.j1  = job_last;
    if (s1.drain) begin
      push_entry.j1 = job_drain;
    end else if (s1.e_first && s1.e_last) begin
      push_entry.two = 1'b1;
    end else if (s1.e_first) begin
      push_entry.j1 = job_first;
    end
  end

  assign push = s1_valid && s1.push;

  // Column window: last two columns seen
  always_ff @(posedge clk) begin
    if (s1_valid) begin
      if (s1.drain) begin
        win_p1 <= col_a;
      end else begin
        win_p2 <= win_p1;
        win_p1 <= cur_col;
      end
    end
  end

`ifndef SYNTHESIS
  // Raster column never runs past the frame's last column
  a_col_bound: assert property (@(posedge clk) disable iff (rst)
    !draining |-> (in_col <= wm1))
    else $error("input column beyond frame width");

  // Drain column stays inside the frame
  a_drain_bound: assert property (@(posedge clk) disable iff (rst)
    draining |-> ((drain_col <= wm1) && (in_col == '0) && (in_row == '0)))
    else $error("drain column beyond frame width");
`endif

endmodule

`default_nettype wire

>>> rtl/sobg_back.sv
// Back end: takes jobs from the queue, forms both kernel sums, then the
// saturated magnitude into the output register. Depends on sobg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sobg_back
  import sobg_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  entry_t             head,
  input  logic               head_valid,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [9:0]         out_col,
  output logic [9:0]         out_row,
  output logic signed [10:0] grad_a,
  output logic signed [10:0] grad_b,
  output logic [7:0]         magnitude,
  output logic               run_end,
  output logic               frame_end
);

  logic               half;
  logic               ready_out, ready_a, take;
  job_t               job;

  logic               a_valid;
  logic [9:0]         a_x, a_y;
  logic signed [10:0] a_ga, a_gb;
  logic               a_re, a_fe;

  // 1-2-1 weighted sum of three pixels, at most 1020
  function automatic logic [10:0] tap_sum(input logic [7:0] p0, input logic [7:0] p1,
                                          input logic [7:0] p2);
    return 11'(p0) + {2'b00, p1, 1'b0} + 11'(p2);
  endfunction

  // |a|/2 + |b|/2, each halved with truncation, saturated
  function automatic logic [7:0] mag(input logic signed [10:0] a, input logic signed [10:0] b);
    logic [10:0] ua;
    logic [10:0] ub;
    logic [9:0]  s;
    ua = a[10] ? 11'(-a) : 11'(a);
    ub = b[10] ? 11'(-b) : 11'(b);
    s  = 10'(ua[10:1]) + 10'(ub[10:1]);
    return (s > 10'(SAT_MAX)) ? SAT_MAX : s[7:0];
  endfunction

  // Pipeline advance and job selection
  assign ready_out = !out_valid || !out_stall;
  assign ready_a   = !a_valid || ready_out;
  assign take      = head_valid && ready_a;
  assign pop       = take && (!head.two || half);
  assign job       = (head.two && !half) ? head.j0 : head.j1;

  always_ff @(posedge clk) begin
    if (rst)       half <= 1'b0;
    else if (take) half <= head.two && !half;
  end

  // Kernel sums: first kernel weighs rows, second weighs columns
  always_ff @(posedge clk) begin
    if (rst)          a_valid <= 1'b0;
    else if (ready_a) a_valid <= take;
  end

  always_ff @(posedge clk) begin
    if (ready_a) begin
      a_x  <= job.x;
      a_y  <= job.y;
      a_ga <= $signed(tap_sum(job.l.b, job.c.b, job.r.b) - tap_sum(job.l.t, job.c.t, job.r.t));
      a_gb <= $signed(tap_sum(job.r.t, job.r.m, job.r.b) - tap_sum(job.l.t, job.l.m, job.l.b));
      a_re <= job.run_end;
      a_fe <= job.frame_end;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst)            out_valid <= 1'b0;
    else if (ready_out) out_valid <= a_valid;
  end

  always_ff @(posedge clk) begin
    if (ready_out) begin
      out_col   <= a_x;
      out_row   <= a_y;
      grad_a    <= a_ga;
      grad_b    <= a_gb;
      magnitude <= mag(a_ga, a_gb);
      run_end   <= a_re;
      frame_end <= a_fe;
    end
  end

`ifndef SYNTHESIS
  // Frame's last result is always the last one of its transaction
  a_frame_end_run_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_end) |-> run_end)
    else $error("frame_end without run_end");
`endif

endmodule

`default_nettype wire

>>> rtl/sobel_gradient_3x3.sv
// Top level of the streaming 3x3 Sobel gradient: configuration registers,
// front end, entry queue and back end. Depends on sobg_pkg, sobg_front,
// sobg_queue and sobg_back.
//
//   channel   direction  handshake              payload
//   in        sink       in_valid / in_stall    func, pixel
//   out       source     out_valid / out_stall  out_col, out_row, grad_a, grad_b,
//                                               magnitude, run_end, frame_end
//   cfg       APB slave  psel/penable/pready    paddr, pwdata, prdata
//
// One transaction is accepted per clock while in_stall is low. A result reaches the output
// by way of the line store read, queue write and kernel sums, then magnitude into the output
// register.
// The pixel that closes a frame can give two results; they leave the back end one after
// the other, and the four-entry queue takes up the difference.
// Reset is synchronous; a register write restarts the frame.
// Output stalls back up through the queue to in_stall.
`timescale 1ns / 1ps
`default_nettype none

module sobel_gradient_3x3
  import sobg_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
)
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               func,
  input  logic [7:0]         pixel,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [9:0]         out_col,
  output logic [9:0]         out_row,
  output logic signed [10:0] grad_a,
  output logic signed [10:0] grad_b,
  output logic [7:0]         magnitude,
  output logic               run_end,
  output logic               frame_end
);

  logic [10:0]       frame_width;
  logic [10:0]       frame_height;
  logic              cfg_wr;
  logic              push;
  entry_t            push_entry;
  entry_t            head;
  logic              head_valid;
  logic              pop;
  logic [QLVL_W-1:0] q_level;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= 11'd640;
      frame_height <= 11'd480;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_WIDTH:  frame_width  <= pwdata[10:0];
        REG_HEIGHT: frame_height <= pwdata[10:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_WIDTH:  prdata = {21'd0, frame_width};
      REG_HEIGHT: prdata = {21'd0, frame_height};
      default:    prdata = '0;
    endcase
  end

  sobg_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .restart      (cfg_wr),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .func         (func),
    .pixel        (pixel),
    .q_level      (q_level),
    .push         (push),
    .push_entry   (push_entry)
  );

  sobg_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .level      (q_level)
  );

  sobg_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_col    (out_col),
    .out_row    (out_row),
    .grad_a     (grad_a),
    .grad_b     (grad_b),
    .magnitude  (magnitude),
    .run_end    (run_end),
    .frame_end  (frame_end)
  );

endmodule

`default_nettype wire

>>> tb/sv/sobel_check.sv
// Checker for the 3x3 Sobel gradient block: tracks register writes, predicts the
// gradient results of every accepted transaction and compares them in order.
// Depends on sobg_pkg.
`timescale 1ns / 1ps

module sobel_check
  import sobg_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               func,
  input  logic [7:0]         pixel,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [9:0]         out_col,
  input  logic [9:0]         out_row,
  input  logic signed [10:0] grad_a,
  input  logic signed [10:0] grad_b,
  input  logic [7:0]         magnitude,
  input  logic               run_end,
  input  logic               frame_end,
  output int                 errors,
  output int                 pending
);

  localparam int ROW_SLOTS = 1024;

  typedef struct {
    int col;
    int row;
    int ga;
    int gb;
    int mag;
    bit re;
    bit fe;
  } grad_t;

  grad_t       grad_q[$];
  logic [7:0]  rows[0:3*ROW_SLOTS-1];
  logic [10:0] width_reg, height_reg;
  int          pos_col, pos_row, drain_pos;
  bit          draining;

  function automatic int clamp_size(logic [10:0] v);
    if (v == 0) return 1;
    return (v > ROW_SLOTS) ? ROW_SLOTS : int'(v);
  endfunction

  // Kernel sums for one position; the pixel arriving now is not yet stored
  function automatic grad_t gradient_at(int x, int y, bit has_cur, int cval,
                                        bit re, bit fe);
    grad_t g;
    int w, h, cx, cy, di, dj, v;
    w = clamp_size(width_reg);
    h = clamp_size(height_reg);
    g.ga = 0;
    g.gb = 0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        di = i - 1;
        dj = j - 1;
        cx = x;
        cy = y;
        if (di < 0 && cx > 0) cx--;
        if (di > 0 && cx + 1 < w) cx++;
        if (dj < 0 && cy > 0) cy--;
        if (dj > 0 && cy + 1 < h) cy++;
        if (has_cur && cx == pos_col && cy == pos_row) v = cval;
        else v = rows[(cy % 3) * ROW_SLOTS + (cx % ROW_SLOTS)];
        // First kernel weighs rows (bottom minus top), second weighs columns
        g.ga += v * dj * ((di == 0) ? 2 : 1);
        g.gb += v * di * ((dj == 0) ? 2 : 1);
      end
    end
    g.mag = ((g.ga < 0) ? -g.ga : g.ga) / 2 + ((g.gb < 0) ? -g.gb : g.gb) / 2;
    if (g.mag > SAT_MAX) g.mag = SAT_MAX;
    g.col = x;
    g.row = y;
    g.re  = re;
    g.fe  = fe;
    return g;
  endfunction

  task automatic report(string what, int got, int want);
    if (errors < 40)
      $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  // Advance the frame position for one accepted transaction
  task automatic predict(bit is_drain, int pix);
    int w, h, xs[2], ys[2], n;
    bit last;
    w = clamp_size(width_reg);
    h = clamp_size(height_reg);
    n = 0;
    if (is_drain) begin
      if (draining) begin
        last = (drain_pos + 1 >= w);
        grad_q.push_back(gradient_at(drain_pos, h - 1, 0, 0, 1, last));
        if (last) draining = 0;
        else drain_pos++;
      end
    end else if (!draining) begin
      last = (pos_col + 1 >= w) && (pos_row + 1 >= h);
      if (pos_row >= 1 && pos_col >= 1) begin
        xs[n] = pos_col - 1;
        ys[n] = pos_row - 1;
        n++;
      end else if (pos_col == 0 && pos_row >= 2) begin
        xs[n] = w - 1;
        ys[n] = pos_row - 2;
        n++;
      end
      if (last && h >= 2) begin
        xs[n] = w - 1;
        ys[n] = h - 2;
        n++;
      end
      for (int k = 0; k < n; k++)
        grad_q.push_back(gradient_at(xs[k], ys[k], 1, pix, k == n - 1, 0));
      rows[(pos_row % 3) * ROW_SLOTS + (pos_col % ROW_SLOTS)] = pix[7:0];
      if (last) begin
        pos_col   = 0;
        pos_row   = 0;
        drain_pos = 0;
        draining  = 1;
      end else if (pos_col + 1 >= w) begin
        pos_col = 0;
        pos_row++;
      end else begin
        pos_col++;
      end
    end
  endtask

  initial errors = 0;

  always @(posedge clk) begin
    grad_t want;
    if (rst) begin
      grad_q.delete();
      width_reg  = 11'd640;
      height_reg = 11'd480;
      pos_col    = 0;
      pos_row    = 0;
      drain_pos  = 0;
      draining   = 0;
    end else begin
      // Output side first: a result never belongs to a transaction of this edge
      if (out_valid && !out_stall) begin
        if (grad_q.size() == 0) begin
          report("unexpected result, column", out_col, -1);
        end else begin
          want = grad_q.pop_front();
          if (out_col != want.col[9:0]) report("out_col", out_col, want.col);
          if (out_row != want.row[9:0]) report("out_row", out_row, want.row);
          if (grad_a != want.ga[10:0]) report("grad_a", grad_a, want.ga);
          if (grad_b != want.gb[10:0]) report("grad_b", grad_b, want.gb);
          if (magnitude != want.mag[7:0]) report("magnitude", magnitude, want.mag);
          if (run_end != want.re) report("run_end", run_end, want.re);
          if (frame_end != want.fe) report("frame_end", frame_end, want.fe);
        end
      end
      if (in_valid && !in_stall) predict(func == FUNC_DRAIN, pixel);
      // A register write restarts the frame
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_HEIGHT) height_reg = pwdata[10:0];
        else width_reg = pwdata[10:0];
        pos_col   = 0;
        pos_row   = 0;
        drain_pos = 0;
        draining  = 0;
      end
    end
    pending = grad_q.size();
  end

endmodule

>>> tb/sv/tb_top.sv
// Top of the Sobel gradient testbench: clock, reset, register writes, pixel and
// drain stimulus with random idling, and the verdict. Depends on sobg_pkg,
// sobel_gradient_3x3 and sobel_check.
`timescale 1ns / 1ps

module tb_top
  import sobg_pkg::*;
;

  localparam int IDLE_LIMIT  = 2000;
  localparam int SETTLE_CYC  = 12;
  localparam int RAND_ITEMS  = 1400;
  localparam int CUT_MAX     = 200;

  logic               clk = 0;
  logic               rst = 1;
  logic               psel = 0, penable = 0, pwrite = 0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid = 0;
  logic               in_stall;
  logic               func = FUNC_PIXEL;
  logic [7:0]         pixel = '0;
  logic               out_valid;
  logic               out_stall = 0;
  logic [9:0]         out_col, out_row;
  logic signed [10:0] grad_a, grad_b;
  logic [7:0]         magnitude;
  logic               run_end, frame_end;
  int                 errors, pending;
  int                 burst_left = 0;
  int                 stall_mode = 0, stall_cnt = 0, stall_run = 0;
  int                 quiet_cyc = 0;
  int                 item_cnt = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  sobel_gradient_3x3 uut (.*);

  sobel_check chk (.*);

  // Receiver: out_stall follows one of four stall patterns, each picked at random
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt % 64 == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0: out_stall <= 0;
        1: out_stall <= ($urandom_range(0, 2) == 0);
        2: out_stall <= (stall_cnt % 4 == 1);
        default: begin
          if (stall_run > 0) begin
            stall_run <= stall_run - 1;
            out_stall <= 1;
          end else begin
            out_stall <= 0;
            if ($urandom_range(0, 9) == 0) stall_run <= $urandom_range(1, 15);
          end
        end
      endcase
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) quiet_cyc <= 0;
    else quiet_cyc <= quiet_cyc + 1;
    if (quiet_cyc >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Two-phase register write
  task automatic reg_write(logic idx, logic [10:0] val);
    psel    <= 1;
    penable <= 0;
    pwrite  <= 1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {$urandom_range(0, 1) ? 21'($urandom) : 21'd0, val};
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel    <= 0;
    penable <= 0;
  endtask

  // One transaction; the sender idles between bursts of random length
  task automatic send(logic f, logic [7:0] p);
    in_valid <= 1;
    func     <= f;
    pixel    <= p;
    do @(posedge clk); while (in_stall);
    item_cnt++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
                                               : $urandom_range(0, 8);
      if ($urandom_range(0, 1)) begin
        in_valid <= 0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  endtask

  // Wait until every result is out and the pipeline has settled
  task automatic settle;
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  function automatic int clamp_size(logic [10:0] v);
    if (v == 0) return 1;
    return (v > 1024) ? 1024 : int'(v);
  endfunction

  function automatic logic [7:0] rand_pixel;
    case ($urandom_range(0, 3))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  // Configure a frame, send its pixels then its drains, with optional noise
  task automatic run_frame(logic [10:0] w, logic [10:0] h, bit cut, int noise);
    int ew, eh, n, lim;
    settle();
    if ($urandom_range(0, 1)) begin
      reg_write(REG_WIDTH, w);
      reg_write(REG_HEIGHT, h);
    end else begin
      reg_write(REG_HEIGHT, h);
      reg_write(REG_WIDTH, w);
    end
    ew  = clamp_size(w);
    eh  = clamp_size(h);
    lim = (ew * eh > CUT_MAX) ? CUT_MAX : ew * eh;
    n   = cut ? $urandom_range(0, lim - 1) : ew * eh;
    for (int k = 0; k < n; k++) begin
      if (noise > 0 && $urandom_range(0, noise) == 0) send(FUNC_DRAIN, 8'($urandom));
      send(FUNC_PIXEL, rand_pixel());
    end
    if (!cut) begin
      for (int k = 0; k < ew; k++) begin
        if (noise > 0 && $urandom_range(0, noise) == 0) send(FUNC_PIXEL, rand_pixel());
        send(FUNC_DRAIN, 8'($urandom));
      end
      // Drain after the frame is closed is ignored
      if (noise > 0) send(FUNC_DRAIN, 8'd0);
    end
  endtask

  initial begin
    logic [10:0] w, h;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: 3x3 frame with extremes, stray drain first, pixel during drain
    settle();
    reg_write(REG_WIDTH, 11'd3);
    reg_write(REG_HEIGHT, 11'd3);
    send(FUNC_DRAIN, 8'hFF);
    for (int k = 0; k < 9; k++) send(FUNC_PIXEL, (k % 2) ? 8'd255 : 8'd0);
    send(FUNC_DRAIN, 8'd0);
    send(FUNC_PIXEL, 8'hAA);
    send(FUNC_DRAIN, 8'd0);
    send(FUNC_DRAIN, 8'd0);
    // Zero sizes act as one: single pixel frame
    run_frame(11'd0, 11'd0, 0, 0);
    // Two-row frame, single-row frame, one-column frame
    run_frame(11'd4, 11'd2, 0, 0);
    run_frame(11'd5, 11'd1, 0, 0);
    run_frame(11'd1, 11'd4, 0, 0);
    // Tallest frame from a height above the maximum, then an oversized frame cut short
    run_frame(11'd1, 11'd2047, 0, 0);
    run_frame(11'd2047, 11'd2, 1, 0);

    // Random frames, mostly small and well formed, until the item budget is used
    while (item_cnt < RAND_ITEMS) begin
      w = ($urandom_range(0, 15) == 0) ? 11'($urandom_range(0, 1)) : 11'($urandom_range(2, 16));
      h = ($urandom_range(0, 15) == 0) ? 11'($urandom_range(0, 1)) : 11'($urandom_range(2, 8));
      run_frame(w, h, $urandom_range(0, 9) == 0, $urandom_range(0, 1) ? 15 : 0);
    end
    settle();

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
